@@ hw/rtl/dgsd_pkg.sv @@
// Shared types and constants for the dense graph shortest distance block.
`default_nettype none

package dgsd_pkg;

  localparam int unsigned DIST_W     = 20;
  localparam logic [DIST_W-1:0] DIST_MAX = {DIST_W{1'b1}};
  localparam int unsigned NODE_PORT_W = 4;
  localparam int unsigned TIME_PORT_W = 16;

  localparam logic MODE_LOAD  = 1'b0;
  localparam logic MODE_QUERY = 1'b1;

  // Controller to datapath commands
  typedef struct packed {
    logic clr;       // clear one edge entry
    logic load;      // write one edge entry from the request
    logic start;     // latch query nodes, clear finalized flags
    logic init;      // write one tentative distance
    logic scan;      // issue one read of the minimum scan
    logic commit;    // finalize the picked node
    logic relax;     // issue one edge/distance read for relaxation
    logic fread;     // read the destination distance
    logic res_load;  // capture the result into the output register
  } cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic clr_last;
    logic cnt_last;
    logic rng_ok;
    logic pick_ok;
    logic round_last;
  } st_t;

endpackage

`default_nettype wire

@@ hw/rtl/dgsd_ctrl.sv @@
// Sequencing state machine for the shortest distance query.
`default_nettype none

module dgsd_ctrl (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  output logic               in_stall_o,
  input  wire logic          mode_i,
  output logic               out_valid_o,
  input  wire logic          out_stall_i,
  output dgsd_pkg::cmd_t     cmd_o,
  input  dgsd_pkg::st_t      st_i
);
  import dgsd_pkg::*;

  typedef enum logic [10:0] {
    S_CLEAR  = 11'b000_0000_0001,
    S_IDLE   = 11'b000_0000_0010,
    S_INIT   = 11'b000_0000_0100,
    S_SCAN   = 11'b000_0000_1000,
    S_SDRAIN = 11'b000_0001_0000,
    S_COMMIT = 11'b000_0010_0000,
    S_RELAX  = 11'b000_0100_0000,
    S_RDRAIN = 11'b000_1000_0000,
    S_FREAD  = 11'b001_0000_0000,
    S_FWAIT  = 11'b010_0000_0000,
    S_RESULT = 11'b100_0000_0000
  } state_e;

  state_e state_q, state_d;
  logic   out_vld_q, out_vld_d;
  logic   out_free;

  assign out_free    = !out_vld_q || !out_stall_i;
  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_vld_q;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      S_CLEAR: begin
        cmd_o.clr = 1'b1;
        if (st_i.clr_last) state_d = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid_i) begin
          if (mode_i == MODE_LOAD) begin
            cmd_o.load = 1'b1;
          end else begin
            cmd_o.start = 1'b1;
            state_d = st_i.rng_ok ? S_INIT : S_RESULT;
          end
        end
      end
      S_INIT: begin
        cmd_o.init = 1'b1;
        if (st_i.cnt_last) state_d = S_SCAN;
      end
      S_SCAN: begin
        cmd_o.scan = 1'b1;
        if (st_i.cnt_last) state_d = S_SDRAIN;
      end
      S_SDRAIN: state_d = S_COMMIT;
      S_COMMIT: begin
        // nothing left to finalize, or only unreachable nodes remain
        if (st_i.pick_ok) begin
          cmd_o.commit = 1'b1;
          state_d = S_RELAX;
        end else begin
          state_d = S_FREAD;
        end
      end
      S_RELAX: begin
        cmd_o.relax = 1'b1;
        if (st_i.cnt_last) state_d = S_RDRAIN;
      end
      S_RDRAIN: state_d = st_i.round_last ? S_FREAD : S_SCAN;
      S_FREAD: begin
        cmd_o.fread = 1'b1;
        state_d = S_FWAIT;
      end
      S_FWAIT: state_d = S_RESULT;
      S_RESULT: begin
        if (out_free) begin
          cmd_o.res_load = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    out_vld_d = out_vld_q;
    if (cmd_o.res_load) begin
      out_vld_d = 1'b1;
    end else if (!out_stall_i) begin
      out_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_CLEAR;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      out_vld_q <= out_vld_d;
    end
  end

endmodule

`default_nettype wire

@@ hw/rtl/dgsd_dp.sv @@
// Datapath: edge matrix memory, distance memory, min scan and relaxation.
`default_nettype none

module dgsd_dp #(
  parameter int unsigned NODES     = 16,
  parameter int unsigned TIME_BITS = 16
) (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  dgsd_pkg::cmd_t                          cmd_i,
  output dgsd_pkg::st_t                           st_o,
  input  wire logic [dgsd_pkg::NODE_PORT_W-1:0]   from_node_i,
  input  wire logic [dgsd_pkg::NODE_PORT_W-1:0]   to_node_i,
  input  wire logic [dgsd_pkg::TIME_PORT_W-1:0]   edge_time_i,
  output logic [dgsd_pkg::DIST_W-1:0]             distance_o,
  output logic                                    reachable_o
);
  import dgsd_pkg::*;

  localparam int unsigned CELLS  = NODES * NODES;
  localparam int unsigned IDX_W  = $clog2(NODES);
  localparam int unsigned ADDR_W = $clog2(CELLS);
  localparam int unsigned CMP_W  = 8;
  localparam int unsigned LD_W   = ADDR_W + NODE_PORT_W;
  localparam int unsigned SUM_W  = ((TIME_BITS > DIST_W) ? TIME_BITS : DIST_W) + 1;

  // memories
  logic [TIME_BITS-1:0] edge_mem [CELLS];
  logic [DIST_W-1:0]    dist_mem [NODES];
  logic [TIME_BITS-1:0] edge_rd_q;
  logic [DIST_W-1:0]    dist_rd_q;

  // control registers
  logic [ADDR_W-1:0] clr_q;
  logic [IDX_W-1:0]  cnt_q, cnt_d;
  logic [IDX_W-1:0]  rnd_q;
  logic              s_vld_q, r_vld_q;
  logic              found_q;
  logic [NODES-1:0]  fin_q, fin_d;

  // payload registers
  logic [IDX_W-1:0]  src_q, dst_q, idx_d1_q, pick_q;
  logic              bad_q;
  logic [ADDR_W-1:0] rbase_q, rbase_d1_q, pbase_q;
  logic [DIST_W-1:0] best_q, du_q;
  logic [DIST_W-1:0] res_dist_q;
  logic              res_reach_q;

  logic [CMP_W-1:0]     from_w, to_w;
  logic                 ld_ok;
  logic [LD_W-1:0]      ld_full;
  logic [31:0]          et_w;
  logic                 e_we;
  logic [ADDR_W-1:0]    e_waddr;
  logic [TIME_BITS-1:0] e_wdata;
  logic [ADDR_W-1:0]    e_raddr;
  logic                 d_re, d_we;
  logic [IDX_W-1:0]     d_raddr, d_waddr;
  logic [DIST_W-1:0]    d_wdata;
  logic                 scan_hit;
  logic [SUM_W-1:0]     sum_w;
  logic [DIST_W-1:0]    sum_sat;
  logic                 relax_hit;
  logic                 cnt_last;

  assign from_w  = CMP_W'(from_node_i);
  assign to_w    = CMP_W'(to_node_i);
  assign ld_ok   = (from_w < CMP_W'(NODES)) && (to_w < CMP_W'(NODES));
  assign ld_full = LD_W'(from_node_i) * LD_W'(NODES) + LD_W'(to_node_i);
  assign et_w    = 32'(edge_time_i);
  assign cnt_last = (cnt_q == IDX_W'(NODES - 1));

  // edge matrix: clear pass after reset, single-entry loads, row reads on relax
  assign e_we    = cmd_i.clr || (cmd_i.load && ld_ok);
  assign e_waddr = cmd_i.clr ? clr_q : ld_full[ADDR_W-1:0];
  assign e_wdata = cmd_i.clr ? '0 : et_w[TIME_BITS-1:0];
  assign e_raddr = pbase_q + ADDR_W'(cnt_q);

  always_ff @(posedge clk_i) begin
    if (e_we) edge_mem[e_waddr] <= e_wdata;
    if (cmd_i.relax) edge_rd_q <= edge_mem[e_raddr];
  end

  // relaxation compare on the registered read data
  assign sum_w     = SUM_W'(du_q) + SUM_W'(edge_rd_q);
  assign sum_sat   = (sum_w > SUM_W'(DIST_MAX)) ? DIST_MAX : sum_w[DIST_W-1:0];
  assign relax_hit = r_vld_q && !fin_q[idx_d1_q] && (edge_rd_q != '0) &&
                     (sum_sat < dist_rd_q);

  // minimum scan, ties go to the higher index
  assign scan_hit = s_vld_q && !fin_q[idx_d1_q] && (dist_rd_q <= best_q);

  assign d_re    = cmd_i.scan || cmd_i.relax || cmd_i.fread;
  assign d_raddr = cmd_i.fread ? dst_q : cnt_q;
  assign d_we    = cmd_i.init || relax_hit;
  assign d_waddr = cmd_i.init ? cnt_q : idx_d1_q;
  assign d_wdata = cmd_i.init ? ((cnt_q == src_q) ? '0 : DIST_MAX) : sum_sat;

  always_ff @(posedge clk_i) begin
    if (d_we) dist_mem[d_waddr] <= d_wdata;
    if (d_re) dist_rd_q <= dist_mem[d_raddr];
  end

  always_comb begin
    cnt_d = cnt_q;
    if (cmd_i.start) begin
      cnt_d = '0;
    end else if (cmd_i.init || cmd_i.scan || cmd_i.relax) begin
      cnt_d = cnt_last ? '0 : cnt_q + 1'b1;
    end
  end

  always_comb begin
    fin_d = fin_q;
    if (cmd_i.start) begin
      fin_d = '0;
    end else if (cmd_i.commit) begin
      fin_d[pick_q] = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q   <= '0;
      cnt_q   <= '0;
      rnd_q   <= '0;
      s_vld_q <= 1'b0;
      r_vld_q <= 1'b0;
      found_q <= 1'b0;
      fin_q   <= '0;
    end else begin
      if (cmd_i.clr) clr_q <= clr_q + 1'b1;
      cnt_q   <= cnt_d;
      fin_q   <= fin_d;
      s_vld_q <= cmd_i.scan;
      r_vld_q <= cmd_i.relax;
      if (cmd_i.start) begin
        rnd_q <= '0;
      end else if (cmd_i.commit) begin
        rnd_q <= rnd_q + 1'b1;
      end
      if (cmd_i.start || cmd_i.commit) begin
        found_q <= 1'b0;
      end else if (scan_hit) begin
        found_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      src_q <= from_w[IDX_W-1:0];
      dst_q <= to_w[IDX_W-1:0];
      bad_q <= !ld_ok;
    end
    if (cmd_i.scan || cmd_i.relax) idx_d1_q <= cnt_q;
    if (cmd_i.scan) rbase_d1_q <= rbase_q;
    if (cmd_i.start || cmd_i.commit) begin
      rbase_q <= '0;
      best_q  <= DIST_MAX;
    end else begin
      if (cmd_i.scan) rbase_q <= rbase_q + ADDR_W'(NODES);
      if (scan_hit) begin
        best_q  <= dist_rd_q;
        pick_q  <= idx_d1_q;
        pbase_q <= rbase_d1_q;
      end
    end
    if (cmd_i.commit) du_q <= best_q;
    if (cmd_i.res_load) begin
      res_dist_q  <= bad_q ? DIST_MAX : dist_rd_q;
      res_reach_q <= !bad_q && (dist_rd_q != DIST_MAX);
    end
  end

  assign st_o.clr_last   = (clr_q == ADDR_W'(CELLS - 1));
  assign st_o.cnt_last   = cnt_last;
  assign st_o.rng_ok     = ld_ok;
  assign st_o.pick_ok    = found_q && (best_q != DIST_MAX);
  assign st_o.round_last = (rnd_q == IDX_W'(NODES - 1));

  assign distance_o  = res_dist_q;
  assign reachable_o = res_reach_q;

endmodule

`default_nettype wire

@@ hw/rtl/dense_graph_shortest_distance.sv @@
// Top level: shortest travel time over a dense edge-time matrix.
//
//  channel | direction | valid / stall              | payload
//  --------+-----------+----------------------------+--------------------------------------
//  in      | input     | in_valid_i / in_stall_o    | mode_i from_node_i to_node_i edge_time_i
//  out     | output    | out_valid_o / out_stall_i  | distance_o reachable_o
//
// After reset the edge matrix is cleared one entry a cycle, all NODES*NODES entries, with
// in_stall_o high. A load request leaves the controller idle. A query initialises the
// distance memory, then runs rounds and stops early when no reachable node is left;
// each round walks the distance memory one entry a cycle for the minimum and once more for
// relaxation. The result sits in an output register, so the next request is taken while
// it waits on out_stall_i.
`default_nettype none

module dense_graph_shortest_distance #(
  parameter int unsigned NODES     = 16,
  parameter int unsigned TIME_BITS = 16
) (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire logic                               in_valid_i,
  output logic                                    in_stall_o,
  input  wire logic                               mode_i,
  input  wire logic [dgsd_pkg::NODE_PORT_W-1:0]   from_node_i,
  input  wire logic [dgsd_pkg::NODE_PORT_W-1:0]   to_node_i,
  input  wire logic [dgsd_pkg::TIME_PORT_W-1:0]   edge_time_i,
  output logic                                    out_valid_o,
  input  wire logic                               out_stall_i,
  output logic [dgsd_pkg::DIST_W-1:0]             distance_o,
  output logic                                    reachable_o
);
  import dgsd_pkg::*;

  cmd_t cmd;
  st_t  st;

  dgsd_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .mode_i      (mode_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .cmd_o       (cmd),
    .st_i        (st)
  );

  dgsd_dp #(
    .NODES     (NODES),
    .TIME_BITS (TIME_BITS)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .st_o        (st),
    .from_node_i (from_node_i),
    .to_node_i   (to_node_i),
    .edge_time_i (edge_time_i),
    .distance_o  (distance_o),
    .reachable_o (reachable_o)
  );

endmodule

`default_nettype wire
